// ===== design/modular_square_root_core_macros.svh =====
// Assertion macros for the modular square root core.
// Uses the enclosing module's clk and arst_n; no other dependencies.
`ifndef MODULAR_SQUARE_ROOT_CORE_MACROS_SVH
`define MODULAR_SQUARE_ROOT_CORE_MACROS_SVH
`ifndef SYNTH
// Plain property checked at every clock outside reset.
`define MSR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Implication: a condition leads to a consequence in the same cycle.
`define MSR_ASSERT_IMP(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) else $error(msg);
// Implication: a condition leads to a consequence in the next cycle.
`define MSR_ASSERT_NXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) else $error(msg);
`else
`define MSR_ASSERT(lbl, prop, msg)
`define MSR_ASSERT_IMP(lbl, cond, cons, msg)
`define MSR_ASSERT_NXT(lbl, cond, cons, msg)
`endif
`endif

// ===== design/msr_pkg.sv =====
// Shared constants and types for the modular square root core.
// No dependencies.
`default_nettype none
package msr_pkg;
	localparam int VAL_W     = 63;            // operand width
	localparam int CNT_W     = 6;             // bit index / loop counter width
	localparam int CFG_IDX_W = 2;             // config register index width
	localparam logic [CNT_W-1:0] TOP_BIT = CNT_W'(VAL_W - 1);

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NONRES  = 2'd1;

	// Request into the shared modular multiplier
	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] a;
		logic [VAL_W-1:0] b;
		logic [VAL_W-1:0] m;
	} mul_req_t;

	// Status back from the shared modular multiplier
	typedef struct packed {
		logic             busy;
		logic             done;
		logic [VAL_W-1:0] res;
	} mul_rsp_t;
endpackage
`default_nettype wire

// ===== design/msr_ifs.sv =====
// Valid/ready channel interfaces: input item, result item, config write.
// Depends on msr_pkg.
`default_nettype none
interface msr_in_if import msr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] value;
	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface msr_out_if import msr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] root;
	logic             status;
	modport source (output valid, output root, output status, input ready);
	modport sink   (input valid, input root, input status, output ready);
endinterface

interface msr_cfg_if import msr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [VAL_W-1:0]     data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/modular_square_root_core.sv =====
// Tonelli-Shanks modular square root on one shared bit-serial multiplier.
// A modular multiply is issued, runs 63 doubling steps and one add per set bit of b, then signals done.
// Work per item: a zero value takes one reduction; a non-residue one reduction plus Euler's exponentiation
// (63 squarings and a multiply per set exponent bit); a root two reductions, four exponentiations and
// m+2 multiplies per loop pass with m falling from S (at most 62). One item at a time: ready again after the result.
// Async active-low reset: modulus 3, non-residue 2, sequencer idle, no result pending.
`default_nettype none
`include "modular_square_root_core_macros.svh"
module modular_square_root_core import msr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	msr_in_if.sink    in_ch,
	msr_out_if.source out_ch,
	msr_cfg_if.sink   cfg
);
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RED_A = 4'd1;
	localparam logic [3:0] ST_EULER = 4'd2;
	localparam logic [3:0] ST_FACT  = 4'd3;
	localparam logic [3:0] ST_RED_Z = 4'd4;
	localparam logic [3:0] ST_POW_C = 4'd5;
	localparam logic [3:0] ST_POW_T = 4'd6;
	localparam logic [3:0] ST_POW_R = 4'd7;
	localparam logic [3:0] ST_CHECK = 4'd8;
	localparam logic [3:0] ST_SRCH  = 4'd9;
	localparam logic [3:0] ST_SQB   = 4'd10;
	localparam logic [3:0] ST_UPD_C = 4'd11;
	localparam logic [3:0] ST_UPD_T = 4'd12;
	localparam logic [3:0] ST_UPD_R = 4'd13;
	localparam logic [3:0] ST_DONE  = 4'd14;

	localparam logic [VAL_W-1:0] ONE = VAL_W'(1);

	logic [3:0]       state_q;
	logic             wait_q;      // multiply in flight
	logic [VAL_W-1:0] modulus_q, nonres_q;
	logic [VAL_W-1:0] p_q, val_q, a_q, z_q, q_q, c_q, t_q, r_q, tt_q, b_q;
	logic [CNT_W-1:0] s_q, m_q, k_q, i_q;
	logic             fail_q;
	logic [VAL_W-1:0] pw_r_q;
	logic [CNT_W-1:0] pw_k_q;
	logic             pw_mul_q;    // 1: multiply by base pending
	logic             ov_q, ostat_q;
	logic [VAL_W-1:0] oroot_q;

	mul_req_t         mreq;
	mul_rsp_t         mrsp;
	logic             is_pow, need_mul, k_lt_m, pw_last, out_free;
	logic [VAL_W-1:0] pw_base, pw_exp, p_min1, q_plus1;

	// Configuration registers, always writable
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= VAL_W'(3);
			nonres_q  <= VAL_W'(2);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MODULUS: modulus_q <= cfg.data;
				REG_NONRES:  nonres_q  <= cfg.data;
				default:     ;
			endcase
		end
	end

	// Exponentiation operands and multiplier request
	always_comb begin
		p_min1  = p_q - ONE;
		q_plus1 = q_q + ONE;
		is_pow  = (state_q == ST_EULER) || (state_q == ST_POW_C) ||
			(state_q == ST_POW_T) || (state_q == ST_POW_R);
		pw_base = a_q;
		pw_exp  = q_q;
		unique case (state_q)
			ST_EULER: pw_exp = {1'b0, p_min1[VAL_W-1:1]};
			ST_POW_C: pw_base = z_q;
			ST_POW_R: pw_exp = {1'b0, q_plus1[VAL_W-1:1]};
			default:  ;
		endcase
		k_lt_m  = (k_q < m_q);
		pw_last = (pw_k_q == '0);
		need_mul = is_pow || (state_q == ST_RED_A) || (state_q == ST_RED_Z) ||
			(state_q == ST_UPD_C) || (state_q == ST_UPD_T) || (state_q == ST_UPD_R) ||
			(((state_q == ST_SRCH) || (state_q == ST_SQB)) && k_lt_m);
		mreq.start = need_mul && !wait_q;
		mreq.m     = p_q;
		mreq.a     = '0;
		mreq.b     = '0;
		if (is_pow) begin
			mreq.a = pw_r_q;
			mreq.b = pw_mul_q ? pw_base : pw_r_q;
		end else begin
			unique case (state_q)
				ST_RED_A: begin mreq.a = ONE;  mreq.b = val_q;    end
				ST_RED_Z: begin mreq.a = ONE;  mreq.b = nonres_q; end
				ST_SRCH:  begin mreq.a = tt_q; mreq.b = tt_q;     end
				ST_SQB:   begin mreq.a = b_q;  mreq.b = b_q;      end
				ST_UPD_C: begin mreq.a = b_q;  mreq.b = b_q;      end
				ST_UPD_T: begin mreq.a = t_q;  mreq.b = c_q;      end
				ST_UPD_R: begin mreq.a = r_q;  mreq.b = b_q;      end
				default:  ;
			endcase
		end
		out_free = !ov_q || out_ch.ready;
	end

	msr_mulmod u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	assign in_ch.ready   = (state_q == ST_IDLE);
	assign out_ch.valid  = ov_q;
	assign out_ch.root   = oroot_q;
	assign out_ch.status = ostat_q;

	// Current exponent bit of the running exponentiation
	function automatic logic pw_base_bit();
		return pw_exp[pw_k_q];
	endfunction

	// Control: sequencer, handshake flag, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wait_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) ov_q <= 1'b1;
			else if (ov_q && out_ch.ready) ov_q <= 1'b0;
			if (mreq.start) wait_q <= 1'b1;
			else if (mrsp.done) wait_q <= 1'b0;
			unique case (state_q)
				ST_IDLE:  if (in_ch.valid) state_q <= ST_RED_A;
				ST_RED_A: if (wait_q && mrsp.done)
					state_q <= (mrsp.res == '0) ? ST_DONE : ST_EULER;
				ST_EULER: if (wait_q && mrsp.done && !(!pw_mul_q && pw_base_bit()) && pw_last)
					state_q <= (mrsp.res == ONE) ? ST_FACT : ST_DONE;
				ST_FACT:  if (q_q[0]) state_q <= ST_RED_Z;
				ST_RED_Z: if (wait_q && mrsp.done) state_q <= ST_POW_C;
				ST_POW_C, ST_POW_T, ST_POW_R:
					if (wait_q && mrsp.done && !(!pw_mul_q && pw_base_bit()) && pw_last)
						state_q <= state_q + 4'd1;
				ST_CHECK: state_q <= (t_q == ONE) ? ST_DONE : ST_SRCH;
				ST_SRCH: begin
					if (!k_lt_m) state_q <= ST_DONE;
					else if (wait_q && mrsp.done && (mrsp.res == ONE)) state_q <= ST_SQB;
				end
				ST_SQB:   if (!k_lt_m) state_q <= ST_UPD_C;
				ST_UPD_C: if (wait_q && mrsp.done) state_q <= ST_UPD_T;
				ST_UPD_T: if (wait_q && mrsp.done) state_q <= ST_UPD_R;
				ST_UPD_R: if (wait_q && mrsp.done) state_q <= ST_CHECK;
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				p_q      <= (modulus_q < VAL_W'(3)) ? VAL_W'(3) : modulus_q;
				val_q    <= in_ch.value;
				fail_q   <= 1'b0;
				r_q      <= '0;
				pw_r_q   <= ONE;
				pw_k_q   <= TOP_BIT;
				pw_mul_q <= 1'b0;
			end
			ST_RED_A: if (wait_q && mrsp.done) a_q <= mrsp.res;
			ST_EULER, ST_POW_C, ST_POW_T, ST_POW_R: begin
				if (wait_q && mrsp.done) begin
					if (!pw_mul_q && pw_base_bit()) begin
						pw_r_q   <= mrsp.res;
						pw_mul_q <= 1'b1;
					end else begin
						pw_mul_q <= 1'b0;
						if (!pw_last) begin
							pw_r_q <= mrsp.res;
							pw_k_q <= pw_k_q - 1'b1;
						end else begin
							pw_r_q <= ONE;
							pw_k_q <= TOP_BIT;
							unique case (state_q)
								ST_EULER: begin
									fail_q <= (mrsp.res != ONE);
									q_q    <= p_min1;
									s_q    <= '0;
								end
								ST_POW_C: c_q <= mrsp.res;
								ST_POW_T: t_q <= mrsp.res;
								default: begin
									r_q <= mrsp.res;
									m_q <= s_q;
								end
							endcase
						end
					end
				end
			end
			ST_FACT: begin
				if (!q_q[0]) begin
					q_q <= {1'b0, q_q[VAL_W-1:1]};
					s_q <= s_q + 1'b1;
				end
			end
			ST_RED_Z: if (wait_q && mrsp.done) z_q <= mrsp.res;
			ST_CHECK: begin
				tt_q <= t_q;
				k_q  <= CNT_W'(1);
			end
			ST_SRCH: begin
				if (!k_lt_m) begin
					fail_q <= 1'b1;
					r_q    <= '0;
				end else if (wait_q && mrsp.done) begin
					tt_q <= mrsp.res;
					if (mrsp.res == ONE) begin
						i_q <= k_q;
						b_q <= c_q;
						k_q <= k_q + 1'b1;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
			end
			ST_SQB: begin
				if (!k_lt_m) begin
					m_q <= i_q;
				end else if (wait_q && mrsp.done) begin
					b_q <= mrsp.res;
					k_q <= k_q + 1'b1;
				end
			end
			ST_UPD_C: if (wait_q && mrsp.done) c_q <= mrsp.res;
			ST_UPD_T: if (wait_q && mrsp.done) t_q <= mrsp.res;
			ST_UPD_R: if (wait_q && mrsp.done) r_q <= mrsp.res;
			ST_DONE: begin
				if (out_free) begin
					oroot_q <= fail_q ? '0 : r_q;
					ostat_q <= fail_q;
				end
			end
			default: ;
		endcase
	end

	`MSR_ASSERT_IMP(a_no_root_zero, out_ch.valid && out_ch.status, out_ch.root == '0, "non-residue result carries a root")
	`MSR_ASSERT_IMP(a_mul_free, mreq.start, !mrsp.busy && !mrsp.done, "multiply issued while unit busy")
	`MSR_ASSERT_NXT(a_accept_seq, in_ch.valid && in_ch.ready, state_q == ST_RED_A && !wait_q, "accepted item did not start reduction")
	`MSR_ASSERT_IMP(a_reduced, state_q == ST_EULER, a_q < p_q, "residue not reduced below modulus")
	`MSR_ASSERT(a_m_range, state_q < ST_CHECK || state_q == ST_DONE || m_q <= TOP_BIT, "loop bound exceeds exponent width")
endmodule
`default_nettype wire

// ===== design/msr_mulmod.sv =====
// Bit-serial modular multiplier: one modular add per cycle, MSB first.
// Depends on msr_pkg.
`default_nettype none
module msr_mulmod import msr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mul_req_t req,
	output mul_rsp_t      rsp
);
	logic [VAL_W-1:0] acc_q, a_q, b_q, m_q;
	logic [CNT_W-1:0] bit_q;
	logic             add_ph_q;  // 1: adding the multiplicand
	logic             busy_q, done_q;

	logic [VAL_W-1:0] add_y;
	logic [VAL_W:0]   sum, diff;
	logic [VAL_W-1:0] add_res;
	logic             last_bit;

	// One modular add: acc + acc or acc + a
	always_comb begin
		add_y   = add_ph_q ? a_q : acc_q;
		sum     = {1'b0, acc_q} + {1'b0, add_y};
		diff    = sum - {1'b0, m_q};
		add_res = (sum >= {1'b0, m_q}) ? diff[VAL_W-1:0] : sum[VAL_W-1:0];
		last_bit = (bit_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			add_ph_q <= 1'b0;
			bit_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q   <= 1'b1;
				add_ph_q <= 1'b0;
				bit_q    <= TOP_BIT;
			end else if (busy_q) begin
				if (!add_ph_q && b_q[bit_q]) begin
					add_ph_q <= 1'b1;
				end else begin
					add_ph_q <= 1'b0;
					if (last_bit) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
			end
		end
	end

	// Operand and accumulator registers
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			a_q   <= req.a;
			b_q   <= req.b;
			m_q   <= req.m;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= add_res;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.res  = acc_q;
endmodule
`default_nettype wire

// ===== tb/sv/tb_modular_square_root_core.sv =====
// Self-checking testbench for modular_square_root_core (Tonelli-Shanks square root).
// Depends on msr_pkg, the msr_*_if interfaces and the core itself.
`timescale 1ns / 1ps
`default_nettype none
module tb_modular_square_root_core import msr_pkg::*; ();

	localparam logic [63:0] VMASK = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam int LIMIT_CYCLES = 250_000_000;
	localparam int HOLD_CYCLES  = 200_000;
	localparam int RAND_ITEMS   = 100;

	typedef struct {
		logic [VAL_W-1:0] root;
		logic             status;
	} sqrt_res_t;

	// one row of the directed table: a register write or an item
	typedef struct {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [VAL_W-1:0]     data;
		bit                   typed;
		sqrt_res_t            want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	msr_in_if  in_ch ();
	msr_out_if out_ch ();
	msr_cfg_if cfg ();

	modular_square_root_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source),
		.cfg    (cfg.sink)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// register mirror and pending results
	logic [VAL_W-1:0] p_reg = VAL_W'(3);
	logic [VAL_W-1:0] z_reg = VAL_W'(2);
	sqrt_res_t        pending_roots[$];
	int               errors = 0;
	bit               quiet = 0;
	bit               hold_req = 0;
	row_t             rows[$];

	// ---------------- predictor ----------------
	function automatic logic [63:0] add_m(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		logic [63:0] s;
		s = a + b;
		return (s >= m) ? s - m : s;
	endfunction

	function automatic logic [63:0] mul_m(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		logic [63:0] r;
		r = 0;
		for (int k = VAL_W - 1; k >= 0; k--) begin
			r = add_m(r, r, m);
			if (b[k])
				r = add_m(r, a, m);
		end
		return r;
	endfunction

	function automatic logic [63:0] pow_m(logic [63:0] b, logic [63:0] e, logic [63:0] m);
		logic [63:0] r;
		r = 64'd1 % m;
		for (int k = VAL_W - 1; k >= 0; k--) begin
			r = mul_m(r, r, m);
			if (e[k])
				r = mul_m(r, b, m);
		end
		return r;
	endfunction

	function automatic sqrt_res_t tonelli_shanks(logic [VAL_W-1:0] val);
		logic [63:0] p, a, z, q, s, m, c, t, r, tt, i, b;
		sqrt_res_t res;
		p = {1'b0, p_reg};
		if (p < 3)
			p = 3;
		a = {1'b0, val} % p;
		res.root = '0;
		res.status = 1'b0;
		if (a == 0)
			return res;
		if (pow_m(a, (p - 1) / 2, p) != 1) begin
			res.status = 1'b1;
			return res;
		end
		q = p - 1;
		s = 0;
		while (q != 0 && q[0] == 1'b0) begin
			q = q >> 1;
			s++;
		end
		z = {1'b0, z_reg} % p;
		m = s;
		c = pow_m(z, q, p);
		t = pow_m(a, q, p);
		r = pow_m(a, (q + 1) / 2, p);
		while (t != 1) begin
			tt = t;
			i = 0;
			for (logic [63:0] k = 1; k < m; k++) begin
				tt = mul_m(tt, tt, p);
				if (tt == 1) begin
					i = k;
					break;
				end
			end
			// search exhausted: no root reported
			if (i == 0) begin
				res.status = 1'b1;
				return res;
			end
			b = c;
			for (logic [63:0] k = i + 1; k < m; k++)
				b = mul_m(b, b, p);
			m = i;
			c = mul_m(b, b, p);
			t = mul_m(t, c, p);
			r = mul_m(r, b, p);
		end
		res.root = r[VAL_W-1:0];
		return res;
	endfunction

	// ---------------- drivers ----------------
	task automatic report(string what, logic [63:0] want, logic [63:0] got);
		$display("MISMATCH %s: expected %0d got %0d at %0t", what, want, got, $realtime);
		errors++;
	endtask

	task automatic send_item(logic [VAL_W-1:0] val, bit typed, sqrt_res_t want);
		in_ch.valid <= 1'b1;
		in_ch.value <= val;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		pending_roots.push_back(typed ? want : tonelli_shanks(val));
	endtask

	task automatic maybe_gap();
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// write a register once every pending result is back
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
		in_ch.valid <= 1'b0;
		while (pending_roots.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		if (idx == REG_MODULUS)
			p_reg = data;
		else
			z_reg = data;
	endtask

	function automatic logic [VAL_W-1:0] rand63();
		logic [63:0] x;
		x = {$urandom, $urandom};
		return x[VAL_W-1:0];
	endfunction

	function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
		row_t rw;
		rw.is_cfg = 1;
		rw.idx = idx;
		rw.data = data;
		rw.typed = 0;
		rows.push_back(rw);
	endfunction

	function automatic void add_val(logic [VAL_W-1:0] val, bit typed = 0,
	                                logic [VAL_W-1:0] root = '0, logic status = 1'b0);
		row_t rw;
		rw.is_cfg = 0;
		rw.data = val;
		rw.typed = typed;
		rw.want.root = root;
		rw.want.status = status;
		rows.push_back(rw);
	endfunction

	// ---------------- result checker ----------------
	always @(posedge clk) begin
		sqrt_res_t w;
		if (out_ch.valid && out_ch.ready) begin
			if (pending_roots.size() == 0) begin
				report("unexpected item", 64'd0, {1'b0, out_ch.root});
			end else begin
				w = pending_roots.pop_front();
				if (out_ch.root !== w.root)
					report("root", {1'b0, w.root}, {1'b0, out_ch.root});
				if (out_ch.status !== w.status)
					report("status", {63'd0, w.status}, {63'd0, out_ch.status});
			end
		end
	end

	// ---------------- receiver: bursts and one long hold ----------------
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_ch.ready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
				out_ch.ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 15) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// ---------------- watchdog ----------------
	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// ---------------- stimulus ----------------
	initial begin
		logic [63:0] primes[7];
		logic [63:0] zs[7];
		logic [63:0] p, x;
		int sel, pick;
		sqrt_res_t none;

		primes = '{64'd3, 64'd13, 64'd17, 64'd998244353, 64'd3221225473,
		           64'd2305843009213693951, 64'd9223372036854775783};
		zs     = '{64'd2, 64'd2, 64'd3, 64'd3, 64'd5,
		           64'd2305843009213693950, 64'd9223372036854775782};
		none.root = '0;
		none.status = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.value = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_MODULUS;
		cfg.data = '0;

		// directed table
		add_val(VAL_W'(0), 1, VAL_W'(0), 1'b0);          // zero value
		add_val(VAL_W'(1), 1, VAL_W'(1), 1'b0);
		add_val(VAL_W'(2), 1, VAL_W'(0), 1'b1);          // non-residue
		add_val(VAL_W'(VMASK));                          // value far above modulus
		add_cfg(REG_MODULUS, VAL_W'(13));
		add_val(VAL_W'(12));
		add_val(VAL_W'(4));
		add_val(VAL_W'(10));
		add_val(VAL_W'(5));
		add_cfg(REG_NONRES, VAL_W'(4));                  // bad z: residue
		add_val(VAL_W'(12));
		add_val(VAL_W'(3));
		add_cfg(REG_MODULUS, VAL_W'(0));                 // small modulus acts as 3
		add_cfg(REG_NONRES, VAL_W'(0));
		add_val(VAL_W'(3), 1, VAL_W'(0), 1'b0);
		add_val(VAL_W'(5), 1, VAL_W'(0), 1'b1);
		add_val(VAL_W'(4));
		add_cfg(REG_MODULUS, VAL_W'(VMASK));             // composite, largest value
		add_cfg(REG_NONRES, VAL_W'(VMASK));
		add_val(VAL_W'(VMASK), 1, VAL_W'(0), 1'b0);
		add_val(VAL_W'(4));
		add_cfg(REG_MODULUS, VAL_W'(64'd3221225473));    // S = 30
		add_cfg(REG_NONRES, VAL_W'(5));
		add_val(VAL_W'(64'd3221225472));
		add_val(VAL_W'(9));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[n]) begin
			if (rows[n].is_cfg) begin
				write_reg(rows[n].idx, rows[n].data);
			end else begin
				send_item(rows[n].data, rows[n].typed, rows[n].want);
				maybe_gap();
			end
		end

		// random phases; the last one without idling, one with arbitrary registers
		for (int ph = 0; ph < 5; ph++) begin
			if (ph == 2) begin
				write_reg(REG_MODULUS, rand63() | VAL_W'(1));
				write_reg(REG_NONRES, rand63());
			end else begin
				sel = (ph == 0) ? 1 : $urandom_range(0, 6);
				write_reg(REG_MODULUS, primes[sel][VAL_W-1:0]);
				write_reg(REG_NONRES, zs[sel][VAL_W-1:0]);
			end
			if (ph == 4)
				quiet = 1;
			if (ph == 0)
				hold_req = 1;
			p = {1'b0, p_reg};
			if (p < 3)
				p = 3;
			for (int n = 0; n < RAND_ITEMS / 5; n++) begin
				pick = $urandom_range(0, 19);
				if (pick < 12) begin
					x = {1'b0, rand63()} % p;
					x = mul_m(x, x, p);
				end else if (pick < 17) begin
					x = {1'b0, rand63()} % p;
				end else begin
					x = {1'b0, rand63()};
				end
				send_item(x[VAL_W-1:0], 0, none);
				maybe_gap();
			end
		end
		in_ch.valid <= 1'b0;

		while (pending_roots.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+design
design/msr_pkg.sv
design/msr_ifs.sv
design/msr_mulmod.sv
design/modular_square_root_core.sv
tb/sv/tb_modular_square_root_core.sv
